[hdl/rlqm_pkg.sv]
// radio link quality monitor: shared types and constants
// no dependencies
`default_nettype none
package rlqm_pkg;

  localparam int unsigned DivisorW = 33;
  localparam logic [15:0] WindowReset = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_DIV_GO,
    ST_DIV_RUN,
    ST_SCORE,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    DIV_LOSS,
    DIV_RATE,
    DIV_AVG,
    DIV_PEN
  } div_sel_e;

  typedef struct packed {
    logic     accept_pkt;
    logic     accept_tick;
    logic     div_start;
    div_sel_e div_sel;
    logic     finish;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic over;
    logic div_done;
    logic out_free;
  } dp_status_t;

  // floor(ex * 30 / 17) for ex in 0..17
  function automatic logic [4:0] jitter_penalty(input logic [4:0] ex);
    logic [4:0] p;
    case (ex)
      5'd0:  p = 5'd0;
      5'd1:  p = 5'd1;
      5'd2:  p = 5'd3;
      5'd3:  p = 5'd5;
      5'd4:  p = 5'd7;
      5'd5:  p = 5'd8;
      5'd6:  p = 5'd10;
      5'd7:  p = 5'd12;
      5'd8:  p = 5'd14;
      5'd9:  p = 5'd15;
      5'd10: p = 5'd17;
      5'd11: p = 5'd19;
      5'd12: p = 5'd21;
      5'd13: p = 5'd22;
      5'd14: p = 5'd24;
      5'd15: p = 5'd26;
      5'd16: p = 5'd28;
      default: p = 5'd30;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

[hdl/rlqm_div.sv]
// radio link quality monitor: serial restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none
module rlqm_div #(
  parameter int unsigned DW = 36,
  parameter int unsigned SW = 33
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [SW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quotient_o
);
  localparam int unsigned CntW = $clog2(DW);

  logic [DW-1:0]   dvd_q;
  logic [SW-1:0]   rem_q, dsr_q;
  logic [CntW-1:0] cnt_q;
  logic            run_q, done_q;
  logic [SW:0]     shifted, diff;

  assign shifted = {rem_q, dvd_q[DW-1]};
  assign diff    = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      if (!diff[SW]) begin
        rem_q <= diff[SW-1:0];
        dvd_q <= {dvd_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[SW-1:0];
        dvd_q <= {dvd_q[DW-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;
endmodule
`default_nettype wire

[hdl/rlqm_ctrl.sv]
// radio link quality monitor: sequencing state machine
// depends on rlqm_pkg
`default_nettype none
module rlqm_ctrl
  import rlqm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       command_i,
  output logic            in_stall_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);
  state_e   state_q, state_d;
  div_sel_e sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= DIV_LOSS;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = command_i ? ST_TICK : ST_EMIT;
      end
      ST_TICK: begin
        sel_d   = DIV_LOSS;
        state_d = status_i.over ? ST_DIV_GO : ST_IDLE;
      end
      ST_DIV_GO: state_d = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (status_i.div_done) begin
          if (sel_q == DIV_PEN) begin
            state_d = ST_SCORE;
          end else begin
            sel_d   = div_sel_e'(sel_q + 2'd1);
            state_d = ST_DIV_GO;
          end
        end
      end
      ST_SCORE: state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o        = (state_q != ST_IDLE);
    cmd_o             = '0;
    cmd_o.div_sel     = sel_q;
    cmd_o.accept_pkt  = (state_q == ST_IDLE) && in_valid_i && !command_i;
    cmd_o.accept_tick = (state_q == ST_IDLE) && in_valid_i && command_i;
    cmd_o.div_start   = (state_q == ST_DIV_GO);
    cmd_o.finish      = (state_q == ST_SCORE);
    cmd_o.load_out    = (state_q == ST_EMIT) && status_i.out_free;
  end
endmodule
`default_nettype wire

[hdl/rlqm_dp.sv]
// radio link quality monitor: statistics registers, report arithmetic, output register
// depends on rlqm_pkg and rlqm_div
`default_nettype none
module rlqm_dp
  import rlqm_pkg::*;
#(
  parameter int unsigned CW = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_status_t       status_o,
  input  wire logic        cfg_valid_i,
  input  wire logic [15:0] cfg_window_ms_i,
  input  wire logic [7:0]  seq_num_i,
  input  wire logic        first_packet_i,
  input  wire logic        signal_detect_i,
  input  wire logic        out_stall_i,
  output logic             out_valid_o,
  output logic             kind_o,
  output logic             seq_gap_o,
  output logic [7:0]       gap_size_o,
  output logic [9:0]       loss_per_mille_o,
  output logic [15:0]      pkt_rate_o,
  output logic [15:0]      jitter_avg_x10_o,
  output logic [15:0]      jitter_peak_ms_o,
  output logic             last_detect_o,
  output logic [6:0]       quality_o
);
  localparam int unsigned DW = (CW + 10 > 36) ? CW + 10 : 36;

  logic [15:0]   window_q;
  logic [31:0]   time_q, start_q, last_q, isum_q, peak_q, elapsed_q;
  logic [CW-1:0] rx_q, miss_q, dsum_q;
  logic          fresh_q, det_q;
  logic [7:0]    exp_q;

  logic [7:0]    expect_now, gap;
  logic [CW:0]   rx_inc, miss_add, dsum_add;
  logic [31:0]   dt, time_inc;
  logic [32:0]   isum_add;

  assign expect_now = first_packet_i ? seq_num_i : exp_q;
  assign gap        = seq_num_i - expect_now;
  assign rx_inc     = {1'b0, rx_q} + (CW+1)'(1);
  assign miss_add   = {1'b0, miss_q} + (CW+1)'(gap);
  assign dsum_add   = {1'b0, dsum_q} + (CW+1)'(signal_detect_i);
  assign dt         = time_q - last_q;
  assign isum_add   = {1'b0, isum_q} + {1'b0, dt};
  assign time_inc   = time_q + 32'd1;

  // result staging and quotient registers
  logic          rk_q, rgap_q, rdet_q;
  logic [7:0]    rsize_q;
  logic [9:0]    rloss_q, loss_q;
  logic [15:0]   rrate_q, ravg_q, rpeak_q, rate_q, avg_q;
  logic [6:0]    rqual_q;
  logic [5:0]    pen_q;

  logic          div_done;
  logic [DW-1:0] div_quo, div_dvd;
  logic [DivisorW-1:0] div_dsr;
  logic [CW:0]   total;

  assign total = {1'b0, rx_q} + {1'b0, miss_q};

  always_comb begin
    case (cmd_i.div_sel)
      DIV_LOSS: begin
        div_dvd = DW'(miss_q) * DW'(1000);
        div_dsr = DivisorW'(total);
      end
      DIV_RATE: begin
        div_dvd = DW'(rx_q) * DW'(1000);
        div_dsr = (elapsed_q == 32'd0) ? DivisorW'(1) : DivisorW'(elapsed_q);
      end
      DIV_AVG: begin
        div_dvd = DW'(isum_q) * DW'(10);
        div_dsr = DivisorW'(rx_q - CW'(1));
      end
      default: begin
        div_dvd = DW'(miss_q) * DW'(50);
        div_dsr = DivisorW'(total);
      end
    endcase
  end

  rlqm_div #(.DW(DW), .SW(DivisorW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dsr),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // quality score
  logic          tot_nz, rx_gt1, low_det;
  logic [15:0]   avg_m;
  logic [15:0]   jit_prod;
  logic [4:0]    ex;
  logic [6:0]    score;

  assign tot_nz   = (total != '0);
  assign rx_gt1   = (rx_q > CW'(1));
  assign low_det  = (rx_q != '0) && ({1'b0, dsum_q, 1'b0} < {2'b0, rx_q});
  assign avg_m    = rx_gt1 ? avg_q : 16'd0;
  assign jit_prod = {8'd0, avg_m[7:0]} * 16'd205;

  always_comb begin
    if (avg_m >= 16'd200) ex = 5'd17;
    else if (avg_m >= 16'd40) ex = 5'(jit_prod[15:11] - 5'd3);
    else ex = 5'd0;
  end

  assign score = 7'd100 - (tot_nz ? 7'(pen_q) : 7'd0) - 7'(jitter_penalty(ex))
               - (low_det ? 7'd20 : 7'd0);

  assign status_o.over     = (elapsed_q >= {16'd0, window_q});
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
      time_q   <= '0;
      start_q  <= '0;
      last_q   <= '0;
      isum_q   <= '0;
      peak_q   <= '0;
      rx_q     <= '0;
      miss_q   <= '0;
      dsum_q   <= '0;
      fresh_q  <= 1'b1;
      exp_q    <= '0;
      det_q    <= 1'b0;
      elapsed_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i) window_q <= cfg_window_ms_i;
      if (cmd_i.accept_pkt) begin
        rx_q   <= rx_inc[CW] ? '1 : rx_inc[CW-1:0];
        miss_q <= miss_add[CW] ? '1 : miss_add[CW-1:0];
        dsum_q <= dsum_add[CW] ? '1 : dsum_add[CW-1:0];
        if (!fresh_q) begin
          isum_q <= isum_add[32] ? '1 : isum_add[31:0];
          if (dt > peak_q) peak_q <= dt;
        end
        fresh_q <= 1'b0;
        last_q  <= time_q;
        det_q   <= signal_detect_i;
        exp_q   <= seq_num_i + 8'd1;
      end
      if (cmd_i.accept_tick) begin
        time_q    <= time_inc;
        elapsed_q <= time_inc - start_q;
      end
      if (cmd_i.finish) begin
        start_q <= time_q;
        rx_q    <= '0;
        miss_q  <= '0;
        isum_q  <= '0;
        peak_q  <= '0;
        dsum_q  <= '0;
        fresh_q <= 1'b1;
      end
      if (cmd_i.load_out) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      case (cmd_i.div_sel)
        DIV_LOSS: loss_q <= div_quo[9:0];
        DIV_RATE: rate_q <= div_quo[15:0];
        DIV_AVG:  avg_q  <= div_quo[15:0];
        default:  pen_q  <= div_quo[5:0];
      endcase
    end
    if (cmd_i.accept_pkt) begin
      rk_q    <= 1'b0;
      rgap_q  <= (gap != 8'd0);
      rsize_q <= gap;
      rloss_q <= '0;
      rrate_q <= '0;
      ravg_q  <= '0;
      rpeak_q <= '0;
      rdet_q  <= signal_detect_i;
      rqual_q <= '0;
    end
    if (cmd_i.finish) begin
      rk_q    <= 1'b1;
      rgap_q  <= 1'b0;
      rsize_q <= '0;
      rloss_q <= tot_nz ? loss_q : 10'd0;
      rrate_q <= rate_q;
      ravg_q  <= avg_m;
      rpeak_q <= peak_q[15:0];
      rdet_q  <= det_q;
      rqual_q <= score;
    end
    if (cmd_i.load_out) begin
      kind_o           <= rk_q;
      seq_gap_o        <= rgap_q;
      gap_size_o       <= rsize_q;
      loss_per_mille_o <= rloss_q;
      pkt_rate_o       <= rrate_q;
      jitter_avg_x10_o <= ravg_q;
      jitter_peak_ms_o <= rpeak_q;
      last_detect_o    <= rdet_q;
      quality_o        <= rqual_q;
    end
  end
endmodule
`default_nettype wire

[hdl/radio_link_quality_monitor_top.sv]
// radio link quality monitor: top level, controller plus datapath
// depends on rlqm_pkg, rlqm_ctrl, rlqm_dp
//
//  channel  handshake              word
//  in       in_valid_i/in_stall_o   command, seq_num, first_packet, signal_detect
//  out      out_valid_o/out_stall_i kind .. quality
//  cfg      cfg_valid_i/cfg_ready_o window_ms
//
// a packet goes idle to emit, a tick that closes no window goes tick to idle
// a closing tick runs the serial divider four times in turn, then scores and
// emits; the dividend width is DW = max(COUNT_WIDTH+10, 36)
// reset gives window_ms 1000 and empty statistics
// input is taken again while a result waits on a stalled output
`default_nettype none
module radio_link_quality_monitor_top
  import rlqm_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [7:0]  seq_num_i,
  input  wire logic        first_packet_i,
  input  wire logic        signal_detect_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             kind_o,
  output logic             seq_gap_o,
  output logic [7:0]       gap_size_o,
  output logic [9:0]       loss_per_mille_o,
  output logic [15:0]      pkt_rate_o,
  output logic [15:0]      jitter_avg_x10_o,
  output logic [15:0]      jitter_peak_ms_o,
  output logic             last_detect_o,
  output logic [6:0]       quality_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_window_ms_i
);
  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  rlqm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .command_i (command_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  rlqm_dp #(.CW(COUNT_WIDTH)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_window_ms_i (cfg_window_ms_i),
    .seq_num_i       (seq_num_i),
    .first_packet_i  (first_packet_i),
    .signal_detect_i (signal_detect_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .seq_gap_o       (seq_gap_o),
    .gap_size_o      (gap_size_o),
    .loss_per_mille_o(loss_per_mille_o),
    .pkt_rate_o      (pkt_rate_o),
    .jitter_avg_x10_o(jitter_avg_x10_o),
    .jitter_peak_ms_o(jitter_peak_ms_o),
    .last_detect_o   (last_detect_o),
    .quality_o       (quality_o)
  );
endmodule
`default_nettype wire

[dv/tb_top.sv]
// testbench for radio_link_quality_monitor_top: directed rows then random packet/tick traffic
// results are predicted or literal, checked word by word; depends on rlqm_pkg and the rtl
`default_nettype none
module tb_top
  import rlqm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CountW = 24;
  localparam logic [31:0] CountMax = (32'd1 << CountW) - 32'd1;
  localparam int DrainCycles = 250;

  typedef enum logic {CMD_PACKET = 1'b0, CMD_TICK = 1'b1} cmd_e;
  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_LIT} row_e;

  typedef struct packed {
    logic       kind;
    logic       seq_gap;
    logic [7:0] gap_size;
    logic [9:0] loss;
    logic [15:0] rate;
    logic [15:0] avg;
    logic [15:0] peak;
    logic       det;
    logic [6:0] quality;
  } report_t;

  typedef struct packed {
    row_e       op;
    cmd_e       cmd;
    logic [7:0] seq;
    logic       first;
    logic       det;
    logic [15:0] win;
    report_t    lit;
  } row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, command_i, first_packet_i, signal_detect_i;
  logic [7:0] seq_num_i;
  logic out_valid_o, out_stall_i, kind_o, seq_gap_o, last_detect_o;
  logic [7:0] gap_size_o;
  logic [9:0] loss_per_mille_o;
  logic [15:0] pkt_rate_o, jitter_avg_x10_o, jitter_peak_ms_o;
  logic [6:0] quality_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [15:0] cfg_window_ms_i;

  radio_link_quality_monitor_top u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .seq_num_i, .first_packet_i,
    .signal_detect_i, .out_valid_o, .out_stall_i, .kind_o, .seq_gap_o, .gap_size_o,
    .loss_per_mille_o, .pkt_rate_o, .jitter_avg_x10_o, .jitter_peak_ms_o,
    .last_detect_o, .quality_o, .cfg_valid_i, .cfg_ready_o, .cfg_window_ms_i
  );

  // link statistics mirror
  logic [15:0] win_ms;
  logic [31:0] now_ms, win_start, rx_cnt, miss_cnt, ival_sum, ival_peak, det_sum, last_rx;
  logic        fresh, det_last;
  logic [7:0]  seq_expect;

  report_t     pending_words[$];
  int          fails;
  bit          calm;
  bit          hold_req;

  function automatic logic [31:0] count_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, CountMax}) ? CountMax : s[31:0];
  endfunction

  task automatic link_clear();
    win_start = now_ms;
    rx_cnt = 0;
    miss_cnt = 0;
    ival_sum = 0;
    ival_peak = 0;
    det_sum = 0;
    fresh = 1'b1;
  endtask

  task automatic link_update(input cmd_e cmd, input logic [7:0] seq, input logic first,
                             input logic det, output bit emits, output report_t r);
    logic [7:0]  gap;
    logic [31:0] d, elapsed, jit, ex;
    logic [32:0] s;
    longint unsigned total, rx, miss;
    longint      score;
    r = '0;
    emits = 1'b0;
    if (cmd == CMD_PACKET) begin
      if (first) seq_expect = seq;
      gap = seq - seq_expect;
      rx_cnt = count_add(rx_cnt, 1);
      if (gap != 0) miss_cnt = count_add(miss_cnt, {24'd0, gap});
      if (!fresh) begin
        d = now_ms - last_rx;
        s = {1'b0, ival_sum} + {1'b0, d};
        ival_sum = s[32] ? 32'hFFFF_FFFF : s[31:0];
        if (d > ival_peak) ival_peak = d;
      end
      fresh = 1'b0;
      last_rx = now_ms;
      det_last = det;
      det_sum = count_add(det_sum, {31'd0, det});
      seq_expect = seq + 8'd1;
      r.seq_gap = (gap != 0);
      r.gap_size = gap;
      r.det = det;
      emits = 1'b1;
      return;
    end
    now_ms = now_ms + 1;
    elapsed = now_ms - win_start;
    if (elapsed < {16'd0, win_ms}) return;
    if (elapsed == 0) elapsed = 1;
    rx = rx_cnt;
    miss = miss_cnt;
    total = rx + miss;
    score = 100;
    r.kind = 1'b1;
    if (total > 0) begin
      r.loss = (miss * 1000) / total;
      score -= (miss * 50) / total;
    end
    r.rate = (rx * 1000) / elapsed;
    if (rx > 1) r.avg = (longint'(ival_sum) * 10) / (rx - 1);
    jit = r.avg / 10;
    if (jit > 3) begin
      ex = (jit - 3 > 17) ? 17 : jit - 3;
      score -= (ex * 30) / 17;
    end
    if (rx > 0 && longint'(det_sum) * 2 < rx) score -= 20;
    if (score < 0) score = 0;
    if (score > 100) score = 100;
    r.peak = ival_peak[15:0];
    r.det = det_last;
    r.quality = score[6:0];
    link_clear();
    emits = 1'b1;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("radio_link_quality_monitor_top regression: fail");
    $finish;
  end

  // result side: random stall, one long hold on request
  int  hold_left;
  bit  hold_seen;
  report_t got;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
      hold_seen = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = '{kind_o, seq_gap_o, gap_size_o, loss_per_mille_o, pkt_rate_o,
                jitter_avg_x10_o, jitter_peak_ms_o, last_detect_o, quality_o};
        if (pending_words.size() == 0) begin
          $error("unexpected word %p", got);
          fails++;
        end else begin
          report_t e;
          e = pending_words.pop_front();
          if (e.kind != got.kind) begin $error("kind exp %0d got %0d", e.kind, got.kind); fails++; end
          if (e.seq_gap != got.seq_gap) begin
            $error("seq_gap exp %0d got %0d", e.seq_gap, got.seq_gap); fails++;
          end
          if (e.gap_size != got.gap_size) begin
            $error("gap_size exp %0d got %0d", e.gap_size, got.gap_size); fails++;
          end
          if (e.loss != got.loss) begin
            $error("loss_per_mille exp %0d got %0d", e.loss, got.loss); fails++;
          end
          if (e.rate != got.rate) begin
            $error("pkt_rate exp %0d got %0d", e.rate, got.rate); fails++;
          end
          if (e.avg != got.avg) begin
            $error("jitter_avg_x10 exp %0d got %0d", e.avg, got.avg); fails++;
          end
          if (e.peak != got.peak) begin
            $error("jitter_peak_ms exp %0d got %0d", e.peak, got.peak); fails++;
          end
          if (e.det != got.det) begin
            $error("last_detect exp %0d got %0d", e.det, got.det); fails++;
          end
          if (e.quality != got.quality) begin
            $error("quality exp %0d got %0d", e.quality, got.quality); fails++;
          end
        end
      end
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 6);
      end
    end
  end

  task automatic send(input cmd_e cmd, input logic [7:0] seq, input logic first,
                      input logic det, input bit use_lit, input report_t lit);
    bit      emits;
    report_t r;
    if (!calm && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    seq_num_i <= seq;
    first_packet_i <= first;
    signal_detect_i <= det;
    do @(posedge clk_i); while (in_stall_o);
    link_update(cmd, seq, first, det, emits, r);
    if (emits) pending_words.push_back(use_lit ? lit : r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [15:0] w);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_window_ms_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    win_ms = w;
  endtask

  row_t rows[] = '{
    '{ROW_LIT,  CMD_PACKET, 8'h00, 1'b0, 1'b1, 16'd0, '{0, 0, 0, 0, 0, 0, 0, 1, 0}},
    '{ROW_LIT,  CMD_PACKET, 8'hFF, 1'b0, 1'b0, 16'd0, '{0, 1, 254, 0, 0, 0, 0, 0, 0}},
    '{ROW_LIT,  CMD_PACKET, 8'h00, 1'b0, 1'b1, 16'd0, '{0, 0, 0, 0, 0, 0, 0, 1, 0}},
    '{ROW_LIT,  CMD_PACKET, 8'hC8, 1'b1, 1'b1, 16'd0, '{0, 0, 0, 0, 0, 0, 0, 1, 0}},
    '{ROW_LIT,  CMD_PACKET, 8'h55, 1'b1, 1'b0, 16'd0, '{0, 0, 0, 0, 0, 0, 0, 0, 0}},
    '{ROW_LIT,  CMD_PACKET, 8'hAA, 1'b0, 1'b1, 16'd0, '{0, 1, 84, 0, 0, 0, 0, 1, 0}},
    '{ROW_ITEM, CMD_TICK,   8'h00, 1'b0, 1'b0, 16'd0, '0},
    '{ROW_ITEM, CMD_TICK,   8'h00, 1'b0, 1'b0, 16'd0, '0},
    '{ROW_ITEM, CMD_PACKET, 8'hAB, 1'b0, 1'b0, 16'd0, '0},
    '{ROW_CFG,  CMD_TICK,   8'h00, 1'b0, 1'b0, 16'd0, '0},
    '{ROW_ITEM, CMD_TICK,   8'h00, 1'b0, 1'b0, 16'd0, '0},
    '{ROW_LIT,  CMD_TICK,   8'h00, 1'b0, 1'b0, 16'd0, '{1, 0, 0, 0, 0, 0, 0, 0, 100}},
    '{ROW_ITEM, CMD_PACKET, 8'hAC, 1'b0, 1'b1, 16'd0, '0},
    '{ROW_ITEM, CMD_TICK,   8'h00, 1'b0, 1'b0, 16'd0, '0},
    '{ROW_CFG,  CMD_TICK,   8'h00, 1'b0, 1'b0, 16'd1, '0},
    '{ROW_ITEM, CMD_PACKET, 8'h10, 1'b1, 1'b0, 16'd0, '0},
    '{ROW_ITEM, CMD_TICK,   8'h00, 1'b0, 1'b0, 16'd0, '0},
    '{ROW_CFG,  CMD_TICK,   8'h00, 1'b0, 1'b0, 16'hFFFF, '0},
    '{ROW_ITEM, CMD_PACKET, 8'h11, 1'b0, 1'b1, 16'd0, '0},
    '{ROW_ITEM, CMD_TICK,   8'h00, 1'b0, 1'b0, 16'd0, '0}
  };

  logic [15:0] phase_win[] = '{16'd2, 16'd0, 16'd37, 16'd1, 16'd150, 16'd8, 16'd65535, 16'd5};

  initial begin
    int          budget, det_pct, r;
    logic [7:0]  next_seq, seq;
    logic        first;
    bit          paused;
    in_valid_i = 1'b0;
    command_i = CMD_PACKET;
    seq_num_i = '0;
    first_packet_i = 1'b0;
    signal_detect_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_window_ms_i = WindowReset;
    fails = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    paused = 1'b0;
    win_ms = WindowReset;
    now_ms = 0;
    last_rx = 0;
    seq_expect = 0;
    det_last = 1'b0;
    link_clear();
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].op == ROW_CFG) set_window(rows[i].win);
      else send(rows[i].cmd, rows[i].seq, rows[i].first, rows[i].det,
                rows[i].op == ROW_LIT, rows[i].lit);
    end

    next_seq = seq_expect;
    foreach (phase_win[p]) begin
      set_window(phase_win[p]);
      calm = (p == 2);
      budget = (phase_win[p] == 16'd65535) ? 80 : 280;
      det_pct = $urandom_range(0, 1) ? 80 : 25;
      while (budget > 0) begin
        r = $urandom_range(0, 99);
        first = (r < 5);
        seq = (r < 14) ? 8'($urandom) : next_seq;
        send(CMD_PACKET, seq, first, $urandom_range(0, 99) < det_pct, 1'b0, '0);
        next_seq = seq + 8'd1;
        budget--;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(4, 30) : $urandom_range(0, 3))
        begin
          send(CMD_TICK, 8'($urandom), $urandom_range(0, 1), $urandom_range(0, 1), 1'b0, '0);
          budget--;
        end
        if (p == 1 && budget <= 140) hold_req = 1'b1;
        if (p == 3 && !paused && budget < 150) begin
          paused = 1'b1;
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (pending_words.size() != 0) @(posedge clk_i);
        end
      end
    end
    calm = 1'b0;

    drain();
    if (fails == 0) begin
      $display("radio_link_quality_monitor_top regression: pass");
    end else begin
      $display("radio_link_quality_monitor_top regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
hdl/rlqm_pkg.sv
hdl/rlqm_div.sv
hdl/rlqm_ctrl.sv
hdl/rlqm_dp.sv
hdl/radio_link_quality_monitor_top.sv
dv/tb_top.sv
